// File: rtl/core/uaf_pkg.sv
// uaf_pkg: widths, byte constants, mode codes and the 0xC3 fold table
// for the UTF-8 accent folder. No dependencies.
package uaf_pkg;

   localparam int BYTE_W  = 8;
   localparam int CHAR_W  = 7;
   localparam int COUNT_W = 8;

   localparam logic [BYTE_W-1:0] BYTE_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_CONT   = 8'h80;  // first continuation byte
   localparam logic [BYTE_W-1:0] BYTE_LEAD2  = 8'hC0;  // first byte past continuations
   localparam logic [BYTE_W-1:0] BYTE_LATIN1 = 8'hC3;  // lead of U+00C0..U+00FF
   localparam logic [CHAR_W-1:0] CHAR_QMARK  = 7'h3F;
   localparam logic [COUNT_W-1:0] CAP_RESET  = 8'd39;

   typedef enum logic [2:0] {
      MODE_NORMAL   = 3'b001,
      MODE_AFTER_C3 = 3'b010,
      MODE_SKIP     = 3'b100
   } mode_type;

   // second byte of a 0xC3 pair -> plain letter, '?' otherwise
   function automatic logic [CHAR_W-1:0] fold_second(input logic [BYTE_W-1:0] d);
      logic [CHAR_W-1:0] ch;
      ch = CHAR_QMARK;
      if (d >= 8'h80 && d <= 8'h85)      ch = 7'h41;  // A
      else if (d >= 8'hA0 && d <= 8'hA5) ch = 7'h61;  // a
      else if (d == 8'h87)               ch = 7'h43;  // C
      else if (d == 8'hA7)               ch = 7'h63;  // c
      else if (d >= 8'h88 && d <= 8'h8B) ch = 7'h45;  // E
      else if (d >= 8'hA8 && d <= 8'hAB) ch = 7'h65;  // e
      else if (d >= 8'h8C && d <= 8'h8F) ch = 7'h49;  // I
      else if (d >= 8'hAC && d <= 8'hAF) ch = 7'h69;  // i
      else if (d == 8'h91)               ch = 7'h4E;  // N
      else if (d == 8'hB1)               ch = 7'h6E;  // n
      else if (d >= 8'h92 && d <= 8'h96) ch = 7'h4F;  // O
      else if (d >= 8'hB2 && d <= 8'hB6) ch = 7'h6F;  // o
      else if (d >= 8'h99 && d <= 8'h9C) ch = 7'h55;  // U
      else if (d >= 8'hB9 && d <= 8'hBC) ch = 7'h75;  // u
      else if (d == 8'h9F)               ch = 7'h73;  // s (sharp s)
      return ch;
   endfunction

endpackage

// File: rtl/core/uaf_stream_if.sv
// Valid/ready channel interfaces for the UTF-8 accent folder.
// Depends on uaf_pkg for field widths.
interface uaf_req_if import uaf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface uaf_rsp_if import uaf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              has_char;
   logic              out_last;

   modport source (output valid, output out_char, output has_char, output out_last,
                   input ready);
   modport sink   (input valid, input out_char, input has_char, input out_last,
                   output ready);
endinterface

// File: rtl/core/utf8_latin_accent_fold.sv
// utf8_latin_accent_fold: streaming UTF-8 to ASCII folder, one byte per transfer.
// Depends on uaf_pkg and the channel interfaces in uaf_stream_if.sv.
//
//   channel   dir  payload                           handshake
//   req_chan  in   in_byte[7:0]                      valid/ready
//   rsp_chan  out  out_char[6:0] has_char out_last   valid/ready
//   csr_*     in   csr_wr_data[7:0] (out_capacity)   csr_wr_en, no wait
//
// Cycles: one byte per clock sustained while rsp_chan takes results. A result appears in the cycle after
//   its byte's transfer; the latency is the single result register.
// Reset (synchronous): mode normal, count zero, capacity 39, result empty.
// Stalls: req_chan.ready is high when the result register is empty or is
//   draining in the same cycle, so a held result stops input one-for-one.
module utf8_latin_accent_fold
   import uaf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   uaf_req_if.sink         req_chan,
   uaf_rsp_if.source       rsp_chan,
   input  logic            csr_wr_en,
   input  logic [BYTE_W-1:0] csr_wr_data
);

   // capacity register
   logic [COUNT_W-1:0] cap_ff;

   // string state
   mode_type           mode_ff, mode_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;
   logic               has_char_ff, has_char_in;
   logic               out_last_ff, out_last_in;

   logic               req_xfer;
   logic               produce;     // accepted byte yields a result
   logic [BYTE_W-1:0]  b;
   logic               is_cont;
   logic               cap_full;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign b              = req_chan.in_byte;
   assign is_cont        = (b >= BYTE_CONT) && (b < BYTE_LEAD2);
   assign cap_full       = (count_ff >= cap_ff);

   // fold decision for the byte on the input port
   always_comb begin
      mode_in     = mode_ff;
      count_in    = count_ff;
      produce     = 1'b0;
      out_char_in = '0;
      has_char_in = 1'b0;
      out_last_in = 1'b0;
      if (b == BYTE_NUL) begin
         // terminator: end marker, drop any pending 0xC3
         produce     = 1'b1;
         out_last_in = 1'b1;
         mode_in     = MODE_NORMAL;
         count_in    = '0;
      end else if (cap_full) begin
         // string is full: swallow everything until the terminator
      end else if (mode_ff == MODE_AFTER_C3) begin
         produce     = 1'b1;
         has_char_in = 1'b1;
         out_char_in = fold_second(b);
         mode_in     = MODE_NORMAL;
         count_in    = count_ff + 1'b1;
      end else if (mode_ff == MODE_SKIP && is_cont) begin
         // still inside a dropped sequence
      end else if (b < BYTE_CONT) begin
         produce     = 1'b1;
         has_char_in = 1'b1;
         out_char_in = b[CHAR_W-1:0];
         mode_in     = MODE_NORMAL;
         count_in    = count_ff + 1'b1;
      end else if (b == BYTE_LATIN1) begin
         mode_in = MODE_AFTER_C3;
      end else begin
         // other lead or stray continuation: drop it and its tail
         mode_in = MODE_SKIP;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer && produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         mode_ff      <= MODE_NORMAL;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (req_xfer) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: loaded on a producing transfer, held otherwise
   always_ff @(posedge clock) begin
      if (req_xfer && produce) begin
         out_char_ff <= out_char_in;
         has_char_ff <= has_char_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_char = out_char_ff;
   assign rsp_chan.has_char = has_char_ff;
   assign rsp_chan.out_last = out_last_ff;

`ifndef SYNTH
   // every result is either a character or the end marker, never both
   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (has_char_ff != out_last_ff))
      else $error("result is neither a single character nor an end marker");

   // a terminator clears the string state
   a_term_clear: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_chan.in_byte == BYTE_NUL) |=>
         (count_ff == '0 && mode_ff == MODE_NORMAL))
      else $error("terminator did not clear mode and count");

   // each emitted character bumps the count by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && produce && has_char_in) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("character emitted without count increment");

   // a full string leaves the state untouched for nonzero bytes
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && cap_full && req_chan.in_byte != BYTE_NUL) |=>
         ($stable(count_ff) && $stable(mode_ff) && !($rose(rsp_valid_ff))))
      else $error("full string changed state or produced a result");

   // the count never passes the capacity while it is not rewritten
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && has_char_in && produce) |-> (count_ff < cap_ff))
      else $error("character emitted beyond capacity");
`endif

endmodule
